// ===== design/nca_pkg.sv =====
// Shared types and constants for the nearest-centroid assignment block.
package nca_pkg;

   // Field widths fixed by the item formats.
   localparam int VALUE_W = 16;
   localparam int INDEX_W = 4;
   localparam int TERM_W  = 32;
   localparam int SUM_W   = 36;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   // Item kinds carried in tuser.
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Distance modes.
   localparam logic MODE_EUCLID    = 1'b0;
   localparam logic MODE_MANHATTAN = 1'b1;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_DISTANCE_MODE    = 2'd0;
   localparam logic [1:0] REG_EXCLUDED_FEATURE = 2'd1;
   localparam logic [1:0] REG_CLUSTER_COUNT    = 2'd2;

   // Reset values of the registers.
   localparam logic [4:0] EXCLUDED_RESET = 5'd4;
   localparam logic [4:0] COUNT_RESET    = 5'd2;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DRAIN,
      S_RESULT
   } state_type;

   // Controls for the distance term unit, constant over one item.
   typedef struct packed {
      logic manhattan;
      logic enable;
   } term_ctl_type;

endpackage

// ===== design/nearest_centroid_assign.sv =====
// Nearest-centroid assignment for k-means: centroid store, per-cluster sums, argmin.
//
// Centroid elements are loaded with write items (tuser 0), one per cycle while idle.
// A sample feature item (tuser 1) occupies the block until its walk is done, where k is
// the number of clusters in use: it is accepted, then walks the k clusters in turn
// through the single read port of the centroid memory and of the sum memory (one
// cluster per cycle), then waits while the term pipeline writes the last sum back.
// An item marked tlast then passes through a result state to hand its result to
// the output register, and waits there while an earlier result is still untaken.
// The per-cluster sums clear at reset and after every result through one valid
// bit per cluster, so no clearing pass is needed. Centroid elements that were
// never written read as undefined values.
module nearest_centroid_assign #(
   parameter int MAX_CLUSTERS = 16,
   parameter int MAX_FEATURES = 16
) (
   input  logic        clock,
   input  logic        reset,

   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // cluster_sel[3:0], feature_index[7:4], value[23:8]
   input  logic [0:0]  req_tuser,   // op[0]
   input  logic        req_tlast,   // last

   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // nearest_cluster[3:0], min_distance[39:4]

   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import nca_pkg::*;

   localparam int CW        = $clog2(MAX_CLUSTERS);
   localparam int FW        = $clog2(MAX_FEATURES);
   localparam int CEN_DEPTH = 1 << (CW + FW);
   localparam int SUM_DEPTH = 1 << CW;

   // Configuration registers.
   logic       mode_ff;
   logic [4:0] excluded_ff;
   logic [4:0] count_ff;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_EUCLID;
         excluded_ff <= EXCLUDED_RESET;
         count_ff    <= COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_DISTANCE_MODE:    mode_ff     <= csr_pwdata[0];
            REG_EXCLUDED_FEATURE: excluded_ff <= csr_pwdata[4:0];
            REG_CLUSTER_COUNT:    count_ff    <= csr_pwdata[4:0];
            default:              ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_DISTANCE_MODE:    csr_prdata = {31'd0, mode_ff};
         REG_EXCLUDED_FEATURE: csr_prdata = {27'd0, excluded_ff};
         REG_CLUSTER_COUNT:    csr_prdata = {27'd0, count_ff};
         default:              csr_prdata = '0;
      endcase
   end

   // Input field unpacking.
   logic               in_op;
   logic [INDEX_W-1:0] in_csel;
   logic [INDEX_W-1:0] in_feat;
   logic [VALUE_W-1:0] in_value;
   logic [6:0]         in_csel_ext;
   logic [6:0]         in_feat_ext;
   logic               req_accept;

   assign in_op       = req_tuser[0];
   assign in_csel     = req_tdata[3:0];
   assign in_feat     = req_tdata[7:4];
   assign in_value    = req_tdata[23:8];
   assign in_csel_ext = 7'(in_csel);
   assign in_feat_ext = 7'(in_feat);
   assign req_accept  = req_tvalid && req_tready;

   // Highest cluster index in use, with zero taken as one and a clamp at the top.
   logic [CW-1:0] last_c;

   always_comb begin
      if (count_ff == 5'd0) begin
         last_c = '0;
      end else if (7'(count_ff) > 7'(MAX_CLUSTERS)) begin
         last_c = CW'(MAX_CLUSTERS - 1);
      end else begin
         last_c = CW'(count_ff - 5'd1);
      end
   end

   // Sequencer.
   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          issue;
   logic          rsp_load;
   logic          vld3_ff;
   logic          fin3_ff;
   logic          last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      req_tready = 1'b0;
      issue      = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cnt_in     = '0;
            if (req_tvalid && in_op == OP_SAMPLE) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            issue = 1'b1;
            if (cnt_ff == last_c) begin
               state_in = S_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            if (vld3_ff && fin3_ff) begin
               state_in = last_ff ? S_RESULT : S_IDLE;
            end
         end
         S_RESULT: begin
            if (!rsp_tvalid || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sample item held for the length of its cluster walk.
   logic [FW-1:0]      feat_ff;
   logic [VALUE_W-1:0] val_ff;
   logic               add_en_ff;

   always_ff @(posedge clock) begin
      if (req_accept && in_op == OP_SAMPLE) begin
         feat_ff   <= in_feat_ext[FW-1:0];
         val_ff    <= in_value;
         last_ff   <= req_tlast;
         add_en_ff <= (in_feat_ext < 7'(MAX_FEATURES)) && ({1'b0, in_feat} != excluded_ff);
      end
   end

   // Centroid memory: written by write items, read one cluster per cycle.
   logic [VALUE_W-1:0] cen_mem [CEN_DEPTH];
   logic [VALUE_W-1:0] cen_rd_ff;

   always_ff @(posedge clock) begin
      if (req_accept && in_op == OP_WRITE && in_csel_ext < 7'(MAX_CLUSTERS)
          && in_feat_ext < 7'(MAX_FEATURES)) begin
         cen_mem[{in_csel_ext[CW-1:0], in_feat_ext[FW-1:0]}] <= in_value;
      end
      cen_rd_ff <= cen_mem[{cnt_ff, feat_ff}];
   end

   // Sum memory with a valid bit per cluster; an invalid entry reads as zero.
   logic [SUM_W-1:0]     sum_mem [SUM_DEPTH];
   logic [SUM_W-1:0]     sum_rd_ff;
   logic [SUM_DEPTH-1:0] sum_valid_ff;
   logic                 sumv_rd_ff;
   logic [CW-1:0]        c3_ff;
   logic [SUM_W-1:0]     new_sum;

   always_ff @(posedge clock) begin
      if (vld3_ff) begin
         sum_mem[c3_ff] <= new_sum;
      end
      sum_rd_ff <= sum_mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= '0;
         sumv_rd_ff   <= 1'b0;
      end else begin
         sumv_rd_ff <= sum_valid_ff[cnt_ff];
         if (rsp_load) begin
            sum_valid_ff <= '0;
         end else if (vld3_ff) begin
            sum_valid_ff[c3_ff] <= 1'b1;
         end
      end
   end

   // Pipeline control: stage one has the memory data, stage three the term.
   logic          vld1_ff, vld2_ff;
   logic          fin1_ff, fin2_ff;
   logic [CW-1:0] c1_ff, c2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         vld1_ff <= issue;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   logic [SUM_W-1:0] sum2_ff, sum3_ff;

   always_ff @(posedge clock) begin
      fin1_ff <= (cnt_ff == last_c);
      fin2_ff <= fin1_ff;
      fin3_ff <= fin2_ff;
      c1_ff   <= cnt_ff;
      c2_ff   <= c1_ff;
      c3_ff   <= c2_ff;
      sum2_ff <= sumv_rd_ff ? sum_rd_ff : '0;
      sum3_ff <= sum2_ff;
   end

   // Distance term for the cluster in stage one, ready in stage three.
   term_ctl_type      term_ctl;
   logic [TERM_W-1:0] term;

   assign term_ctl.manhattan = mode_ff;
   assign term_ctl.enable    = add_en_ff;

   nca_term u_term (
      .clock    (clock),
      .ctl      (term_ctl),
      .sample   (val_ff),
      .centroid (cen_rd_ff),
      .term     (term)
   );

   // Saturating accumulate in stage three.
   logic [SUM_W:0] sum_wide;

   always_comb begin
      sum_wide = {1'b0, sum3_ff} + (SUM_W + 1)'(term);
      new_sum  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
   end

   // Running minimum over the new sums of a last item; ties keep the lower index.
   logic [CW-1:0]    best_idx_ff;
   logic [SUM_W-1:0] best_sum_ff;

   always_ff @(posedge clock) begin
      if (vld3_ff && last_ff && (c3_ff == '0 || new_sum < best_sum_ff)) begin
         best_idx_ff <= c3_ff;
         best_sum_ff <= new_sum;
      end
   end

   // Output register.
   logic             rsp_valid_ff;
   logic [INDEX_W-1:0] rsp_idx_ff;
   logic [SUM_W-1:0] rsp_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_idx_ff <= INDEX_W'(best_idx_ff);
         rsp_sum_ff <= best_sum_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_sum_ff, rsp_idx_ff};

   // A new item is only taken once the previous cluster walk has drained.
   a_accept_drained: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (!vld1_ff && !vld2_ff && !vld3_ff))
      else $error("item accepted while the sum pipeline is still busy");

   // Sums are cleared for the next sample once a result is handed over.
   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (sum_valid_ff == '0))
      else $error("cluster sums not cleared after a result");

   // The winner lies among the clusters in use.
   a_winner_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (best_idx_ff <= last_c))
      else $error("winning cluster beyond the clusters in use");

   // A finished walk never lands while the sequencer sits idle.
   a_no_late_write: assert property (@(posedge clock) disable iff (reset)
      vld3_ff |-> (state_ff == S_RUN || state_ff == S_DRAIN))
      else $error("sum write-back outside the cluster walk");

endmodule

// ===== design/nca_term.sv =====
// Two-stage distance term unit: absolute difference, then square or pass.
module nca_term (
   input  logic                          clock,
   input  nca_pkg::term_ctl_type         ctl,
   input  logic signed [nca_pkg::VALUE_W-1:0] sample,
   input  logic signed [nca_pkg::VALUE_W-1:0] centroid,
   output logic [nca_pkg::TERM_W-1:0]    term
);
   import nca_pkg::*;

   logic signed [VALUE_W:0] diff;
   logic        [VALUE_W:0] diff_mag;
   logic [VALUE_W-1:0]      absdiff_ff, absdiff_in;
   term_ctl_type            ctl_ff;
   logic [TERM_W-1:0]       term_ff, term_in;

   // Stage one: magnitude of the difference; it always fits 16 bits.
   always_comb begin
      diff       = {sample[VALUE_W-1], sample} - {centroid[VALUE_W-1], centroid};
      diff_mag   = diff[VALUE_W] ? (~diff + 1'b1) : diff;
      absdiff_in = diff_mag[VALUE_W-1:0];
   end

   // Stage two: square for Euclidean, pass for Manhattan, zero when gated off.
   always_comb begin
      if (!ctl_ff.enable) begin
         term_in = '0;
      end else if (ctl_ff.manhattan == MODE_MANHATTAN) begin
         term_in = TERM_W'(absdiff_ff);
      end else begin
         term_in = TERM_W'(absdiff_ff) * TERM_W'(absdiff_ff);
      end
   end

   always_ff @(posedge clock) begin
      absdiff_ff <= absdiff_in;
      ctl_ff     <= ctl;
      term_ff    <= term_in;
   end

   assign term = term_ff;

endmodule

// ===== tb/nearest_centroid_assign_tb.sv =====
// Self-checking testbench for the nearest-centroid assignment block.
`timescale 1ns / 1ps

module nearest_centroid_assign_tb;
   import nca_pkg::*;

   localparam int MAX_CLUSTERS  = 16;
   localparam int MAX_FEATURES  = 16;
   localparam int STALL_CYCLES  = 400;
   localparam int SETTLE_CYCLES = 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS   = 160;
   localparam int RANDOM_PHASES = 8;

   typedef struct packed {
      logic [INDEX_W-1:0] nearest;
      logic [SUM_W-1:0]   distance;
   } assignment_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // cluster_sel[3:0], feature_index[7:4], value[23:8]
   logic [0:0]  req_tuser = '0;   // op[0]
   logic        req_tlast = 1'b0; // last

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // nearest_cluster[3:0], min_distance[39:4]

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predictor state: centroid store, running sums and register copies.
   logic signed [VALUE_W-1:0] centroid_mem [MAX_CLUSTERS*MAX_FEATURES];
   logic [SUM_W:0]            cluster_sum [MAX_CLUSTERS];
   logic                      model_mode = MODE_EUCLID;
   logic [4:0]                model_excluded = EXCLUDED_RESET;
   logic [4:0]                model_count = COUNT_RESET;

   assignment_type expected_assignments[$];
   int  mismatches = 0;
   int  idle_cycles = 0;
   bit  idle_on = 1'b1;
   bit  stall_request = 1'b0;

   nearest_centroid_assign #(
      .MAX_CLUSTERS(MAX_CLUSTERS),
      .MAX_FEATURES(MAX_FEATURES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #1 clock = ~clock;

   initial begin
      for (int c = 0; c < MAX_CLUSTERS; c++) begin
         cluster_sum[c] = '0;
      end
   end

   // Update the predictor with one accepted item and queue any assignment it causes.
   task automatic predict_assignment(input logic op, input logic [3:0] csel,
                                     input logic [3:0] feat, input logic [15:0] val,
                                     input logic last);
      int k;
      int best;
      logic signed [VALUE_W-1:0] sample;
      logic signed [VALUE_W:0]   diff;
      logic [VALUE_W-1:0]        mag;
      logic [TERM_W-1:0]         term;
      logic [SUM_W:0]            total;
      assignment_type            result;
      sample = val;
      if (op == OP_WRITE) begin
         centroid_mem[csel*MAX_FEATURES + feat] = sample;
         return;
      end
      // Zero clusters behaves as one; counts past the store clamp to its size.
      if (model_count == 0) begin
         k = 1;
      end else if (model_count > MAX_CLUSTERS) begin
         k = MAX_CLUSTERS;
      end else begin
         k = model_count;
      end
      if ({1'b0, feat} != model_excluded) begin
         for (int c = 0; c < k; c++) begin
            diff = sample - centroid_mem[c*MAX_FEATURES + feat];
            mag  = diff[VALUE_W] ? VALUE_W'(-diff) : VALUE_W'(diff);
            term = (model_mode == MODE_EUCLID) ? TERM_W'(mag) * TERM_W'(mag) : TERM_W'(mag);
            total = cluster_sum[c] + term;
            cluster_sum[c] = (total > SUM_MAX) ? {1'b0, SUM_MAX} : total;
         end
      end
      if (!last) begin
         return;
      end
      // Only a strictly smaller sum displaces the current winner.
      best = 0;
      for (int c = 1; c < k; c++) begin
         if (cluster_sum[c] < cluster_sum[best]) begin
            best = c;
         end
      end
      result.nearest  = best[INDEX_W-1:0];
      result.distance = cluster_sum[best][SUM_W-1:0];
      expected_assignments.push_back(result);
      for (int c = 0; c < MAX_CLUSTERS; c++) begin
         cluster_sum[c] = '0;
      end
   endtask

   // Offer one item, after a random gap when gaps are enabled, and wait until it is accepted.
   task automatic send_item(input logic op, input logic [3:0] csel, input logic [3:0] feat,
                            input logic [15:0] val, input logic last);
      int gap;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {val, feat, csel};
      req_tuser  <= op;
      req_tlast  <= last;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      predict_assignment(op, csel, feat, val, last);
   endtask

   // Random Q8.8 value with the extremes drawn often.
   function automatic logic [15:0] rand_value();
      case ($urandom_range(0, 11))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   // One sample: n features, in order or at random positions, the last one marked.
   task automatic send_sample(input int n, input bit in_order);
      logic [3:0] feat;
      for (int i = 0; i < n; i++) begin
         feat = in_order ? 4'(i) : 4'($urandom_range(0, 15));
         send_item(OP_SAMPLE, 4'($urandom()), feat, rand_value(), i == n - 1);
      end
   endtask

   // Stop offering items and let every pending assignment arrive.
   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      while (expected_assignments.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle.
   task automatic write_register(input logic [1:0] index, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         REG_DISTANCE_MODE:    model_mode = data[0];
         REG_EXCLUDED_FEATURE: model_excluded = data[4:0];
         REG_CLUSTER_COUNT:    model_count = data[4:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic mode, input logic [4:0] excluded,
                                 input logic [4:0] count);
      write_register(REG_DISTANCE_MODE, {31'b0, mode});
      write_register(REG_EXCLUDED_FEATURE, {27'b0, excluded});
      write_register(REG_CLUSTER_COUNT, {27'b0, count});
   endtask

   // Every centroid element gets a value before any sample reads one.
   task automatic test_centroid_load();
      for (int c = 0; c < MAX_CLUSTERS; c++) begin
         for (int f = 0; f < MAX_FEATURES; f++) begin
            send_item(OP_WRITE, 4'(c), 4'(f), rand_value(), 1'($urandom()));
         end
      end
   endtask

   // A full sample under the settings left by reset.
   task automatic test_reset_settings();
      send_sample(MAX_FEATURES, 1'b1);
      wait_until_idle();
   endtask

   // Two clusters at an equal, smallest distance: the lower index must win.
   task automatic test_tie_break();
      apply_settings(MODE_EUCLID, 5'd16, 5'd16);
      send_item(OP_WRITE, 4'd3, 4'd0, 16'h0100, 1'b0);
      send_item(OP_WRITE, 4'd7, 4'd0, 16'h0100, 1'b1);
      send_item(OP_SAMPLE, 4'd9, 4'd0, 16'h0100, 1'b1);
      wait_until_idle();
   endtask

   // Largest possible difference in both distance modes.
   task automatic test_extreme_values();
      apply_settings(MODE_MANHATTAN, 5'd16, 5'd2);
      send_item(OP_WRITE, 4'd0, 4'd1, 16'h8000, 1'b0);
      send_item(OP_WRITE, 4'd1, 4'd1, 16'h7FFF, 1'b0);
      send_item(OP_SAMPLE, 4'd0, 4'd1, 16'h7FFF, 1'b1);
      send_item(OP_SAMPLE, 4'd15, 4'd1, 16'h8000, 1'b1);
      wait_until_idle();
      apply_settings(MODE_EUCLID, 5'd16, 5'd2);
      send_item(OP_SAMPLE, 4'd0, 4'd1, 16'h7FFF, 1'b1);
      send_item(OP_SAMPLE, 4'd0, 4'd1, 16'h8000, 1'b1);
      wait_until_idle();
   endtask

   // Cluster counts of zero, one, the maximum and beyond it.
   task automatic test_cluster_count_limits();
      logic [4:0] counts [5] = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31};
      foreach (counts[i]) begin
         apply_settings(1'($urandom()), 5'd16, counts[i]);
         send_sample(2, 1'b1);
         wait_until_idle();
      end
   endtask

   // Excluded feature at both ends of the index range and past it.
   task automatic test_excluded_feature();
      logic [4:0] excluded [4] = '{5'd0, 5'd15, 5'd16, 5'd31};
      foreach (excluded[i]) begin
         apply_settings(MODE_EUCLID, excluded[i], 5'd4);
         send_item(OP_SAMPLE, 4'd0, excluded[i][3:0], 16'h7FFF, 1'b1);
         wait_until_idle();
      end
   endtask

   // Repeated maximal terms without a last mark drive the sum into saturation.
   task automatic test_sum_saturation();
      apply_settings(MODE_EUCLID, 5'd16, 5'd1);
      send_item(OP_WRITE, 4'd0, 4'd2, 16'h8000, 1'b0);
      for (int i = 0; i < 20; i++) begin
         send_item(OP_SAMPLE, 4'($urandom()), 4'd2, 16'h7FFF, i == 19);
      end
      wait_until_idle();
   endtask

   // Phases of random settings, mostly well-formed samples with writes and noise mixed in.
   task automatic test_random_samples();
      int sent;
      int pick;
      int n;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: apply_settings(MODE_EUCLID, 5'd16, 5'd16);
            1: apply_settings(MODE_MANHATTAN, 5'd0, 5'd1);
            2: apply_settings(MODE_EUCLID, 5'd31, 5'd31);
            3: apply_settings(MODE_MANHATTAN, 5'd15, 5'd0);
            default: apply_settings(1'($urandom()), 5'($urandom()), 5'($urandom()));
         endcase
         idle_on = (p % 3) != 2;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_FEATURES) : MAX_FEATURES;
               send_sample(n, $urandom_range(0, 3) != 0);
               sent += n;
            end else if (pick < 9) begin
               send_item(OP_WRITE, 4'($urandom()), 4'($urandom()), rand_value(),
                         1'($urandom()));
               sent++;
            end else begin
               send_item(OP_SAMPLE, 4'($urandom()), 4'($urandom()), rand_value(),
                         1'($urandom()));
               sent++;
            end
         end
         // Close any sample left open so the phase ends with nothing pending.
         send_sample(1, 1'b1);
         wait_until_idle();
      end
      idle_on = 1'b1;
   endtask

   // The receiver holds off for a long stretch while short samples keep coming.
   task automatic test_output_backpressure();
      apply_settings(MODE_EUCLID, 5'd16, 5'd16);
      idle_on = 1'b0;
      stall_request = 1'b1;
      for (int i = 0; i < 10; i++) begin
         send_sample(2, 1'b1);
      end
      wait_until_idle();
      idle_on = 1'b1;
   endtask

   // Result side: random gaps before taking each item, and one long hold-off on request.
   initial begin : result_sink
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = idle_on ? $urandom_range(0, 7) : 0;
         if (stall_request) begin
            gap = STALL_CYCLES;
            stall_request = 1'b0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   task automatic note_mismatch(input string what, input logic [63:0] expected_v,
                                input logic [63:0] actual_v);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch in %s: expected %0d, actual %0d", what, expected_v, actual_v);
      end
   endtask

   // Compare each accepted result with the oldest expected assignment.
   always @(posedge clock) begin
      assignment_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_assignments.size() == 0) begin
            note_mismatch("unexpected result, nearest_cluster", 64'd0, 64'(rsp_tdata[3:0]));
         end else begin
            want = expected_assignments.pop_front();
            if (rsp_tdata[3:0] !== want.nearest) begin
               note_mismatch("nearest_cluster", 64'(want.nearest), 64'(rsp_tdata[3:0]));
            end
            if (rsp_tdata[39:4] !== want.distance) begin
               note_mismatch("min_distance", 64'(want.distance), 64'(rsp_tdata[39:4]));
            end
         end
      end
   end

   // Watchdog: too many cycles in a row with no item moving on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_centroid_load();
      test_reset_settings();
      test_tie_break();
      test_extreme_values();
      test_cluster_count_limits();
      test_excluded_feature();
      test_sum_saturation();
      test_random_samples();
      test_output_backpressure();
      wait_until_idle();
      if (mismatches == 0 && expected_assignments.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
